FILE: hdl/sclfp_pkg.sv
// ----------------------------------------------------------------------------
// sclfp_pkg
// Shared types and constants of the checksummed length-prefixed frame parser.
// ----------------------------------------------------------------------------
package sclfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 2;

	localparam logic [ByteW-1:0] HDR_FIRST  = 8'hAA;
	localparam logic [ByteW-1:0] HDR_SECOND = 8'hBB;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HDR1 = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef enum logic [KindW-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_DROP    = 2'd2
	} kind_t;

	// One result item plus the flag that says whether the step produced one.
	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [ByteW-1:0] data;
		logic [ByteW-1:0] index;
		logic [ByteW-1:0] length;
	} result_t;

endpackage

FILE: hdl/sclfp_core.sv
// ----------------------------------------------------------------------------
// sclfp_core
// Parser state machine: header hunt, length, payload counting and checksum.
// ----------------------------------------------------------------------------
module sclfp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [sclfp_pkg::ByteW-1:0]   rx_byte,
	output sclfp_pkg::result_t            res
);
	import sclfp_pkg::*;

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] taken_q, taken_d;
	logic [ByteW-1:0] len_q, len_d;
	logic [ByteW-1:0] sum_q, sum_d;
	phase_t           resync_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			taken_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			taken_q <= taken_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
		end
	end

	assign resync_phase = (rx_byte == HDR_FIRST) ? PH_HDR1 : PH_IDLE;

	always_comb begin
		phase_d    = phase_q;
		taken_d    = taken_q;
		len_d      = len_q;
		sum_d      = sum_q;
		res        = '0;
		res.kind   = KIND_PAYLOAD;
		res.length = len_q;
		unique case (phase_q)
			PH_IDLE: begin
				phase_d = resync_phase;
			end
			PH_HDR1: begin
				if (rx_byte == HDR_SECOND) begin
					phase_d = PH_LEN;
					taken_d = '0;
					sum_d   = '0;
				end else begin
					phase_d = resync_phase;
				end
			end
			PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = rx_byte;
				taken_d = '0;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				res.valid = 1'b1;
				if (taken_q < len_q) begin
					res.data  = rx_byte;
					res.index = taken_q;
					taken_d   = taken_q + 8'd1;
					sum_d     = sum_q + rx_byte;
				end else if (sum_q == rx_byte) begin
					res.kind = KIND_GOOD;
					phase_d  = PH_IDLE;
				end else begin
					// Bad trailer; it may itself start the next header.
					res.kind = KIND_DROP;
					phase_d  = resync_phase;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/sclfp_out_reg.sv
// ----------------------------------------------------------------------------
// sclfp_out_reg
// Result register that holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module sclfp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sclfp_pkg::result_t res,
	input  logic               take,
	output logic               free,
	output logic               valid,
	output sclfp_pkg::result_t held
);
	import sclfp_pkg::*;

	logic    valid_q;
	result_t held_q;

	assign free  = !valid_q || take;
	assign valid = valid_q;
	assign held  = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held_q <= res;
		end
	end

endmodule

FILE: hdl/sum_checked_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sum_checked_length_frame_parser
// Length-prefixed frame parser with an additive modulo-256 checksum.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  tdata (lowest bit up)                  tuser
//   s_axis    in         rx_byte[7:0]                           -
//   m_axis    out        out_byte, out_index, frame_length      out_kind[1:0]
//
// One byte item is taken per cycle while the sink does not stall the parser. It
// is captured in an input register, the parser state machine evaluates it in
// one short combinational step, and any result item lands in the result
// register. Bytes that produce no result never wait for the sink.
// A stalled sink holds the result register, then the input register, and only
// then drops s_axis_tready. The asynchronous reset returns the parser to its
// idle header hunt with an empty pipeline.
//
module sum_checked_length_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] out_index,
	                                    // [23:16] frame_length
	output logic [1:0]  m_axis_tuser    // [1:0] out_kind
);
	import sclfp_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             advance;
	logic             out_free;
	result_t          res;
	result_t          held;

	// The input register empties when its byte is evaluated. A byte that
	// yields no result is evaluated regardless of the sink.
	assign advance       = valid_s1 && (!res.valid || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	sclfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	sclfp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res.valid),
		.res    (res),
		.take   (m_axis_tready),
		.free   (out_free),
		.valid  (m_axis_tvalid),
		.held   (held)
	);

	assign m_axis_tdata = {held.length, held.index, held.data};
	assign m_axis_tuser = held.kind;

	// A waiting input byte must not be lost or changed before it is evaluated.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost or changed a waiting item");

	// A payload position always lies below the announced length.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD
		|-> m_axis_tdata[15:8] < m_axis_tdata[23:16])
		else $error("payload index not below frame length");

	// Frame end markers carry no byte and no position.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_GOOD || m_axis_tuser == KIND_DROP)
		|-> m_axis_tdata[15:0] == 16'd0)
		else $error("frame end item carries payload fields");

	// The unused kind code never leaves the block.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined result kind");

endmodule
